// ===== src/tcb_pkg.sv =====
// tcb_pkg: shared types, constants and geometry of the text console buffer
// used by tcb_front, tcb_back and the top level; no dependencies
package tcb_pkg;

  localparam int unsigned Cols = 80;
  localparam int unsigned Rows = 25;
  localparam int unsigned Cells = Cols * Rows;
  localparam int unsigned AddrW = $clog2(Cells);
  localparam int unsigned ColW = 7;
  localparam int unsigned RowW = 5;
  localparam int unsigned HwW = 11;
  localparam int unsigned CellW = 16;
  localparam int unsigned QDepth = 2;

  localparam logic [7:0] Space = 8'h20;
  localparam logic [CellW-1:0] ResetCell = 16'h0720;

  // request codes
  localparam logic [2:0] ReqPut = 3'd0;
  localparam logic [2:0] ReqPutXy = 3'd1;
  localparam logic [2:0] ReqGoto = 3'd2;
  localparam logic [2:0] ReqFill = 3'd3;
  localparam logic [2:0] ReqClear = 3'd4;
  localparam logic [2:0] ReqRead = 3'd5;

  // register indexes
  localparam logic [1:0] RegFg = 2'd0;
  localparam logic [1:0] RegBg = 2'd1;
  localparam logic [1:0] RegCurEn = 2'd2;

  // classified request passed from front to back
  typedef struct packed {
    logic [2:0]      req;
    logic [ColW-1:0] x;
    logic [RowW-1:0] y;
    logic [ColW-1:0] ex;
    logic [RowW-1:0] ey;
    logic [7:0]      ch;
  } cmd_t;

  typedef struct packed {
    logic [ColW-1:0]  col;
    logic [RowW-1:0]  row;
    logic [HwW-1:0]   hw;
    logic [CellW-1:0] data;
  } res_t;

endpackage

// ===== src/tcb_ram.sv =====
// tcb_ram: generic single port ram with registered read
// no dependencies
module tcb_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ===== src/tcb_front.sv =====
// tcb_front: accepts requests, clamps and clips positions, queues commands
// depends on tcb_pkg
module tcb_front import tcb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  req_type_i,
  input  logic signed [7:0] pos_x_i,
  input  logic signed [7:0] pos_y_i,
  input  logic [6:0]  end_x_i,
  input  logic [6:0]  end_y_i,
  input  logic [7:0]  char_code_i,
  output logic        cmd_valid_o,
  input  logic        cmd_ready_i,
  output cmd_t        cmd_o
);

  cmd_t q_mem_q [QDepth];
  logic q_wp_q, q_rp_q;
  logic [1:0] q_cnt_q;
  cmd_t c;
  logic push, pop;

  // clamp and clip
  always_comb begin
    c = '0;
    c.req = req_type_i;
    c.ch  = char_code_i;
    if (pos_x_i < 0) c.x = '0;
    else if (pos_x_i >= $signed(9'(Cols))) c.x = ColW'(Cols - 1);
    else c.x = ColW'(pos_x_i);
    if (pos_y_i < 0) c.y = '0;
    else if (pos_y_i >= $signed(9'(Rows))) c.y = RowW'(Rows - 1);
    else c.y = RowW'(pos_y_i);
    c.ex = (end_x_i > 7'(Cols)) ? ColW'(Cols) : ColW'(end_x_i);
    c.ey = (end_y_i > 7'(Rows)) ? RowW'(Rows) : RowW'(end_y_i);
  end

  assign in_ready_o  = (q_cnt_q != 2'(QDepth));
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (q_cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = q_mem_q[q_rp_q];

  // command queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_wp_q  <= 1'b0;
      q_rp_q  <= 1'b0;
      q_cnt_q <= '0;
    end else begin
      if (push) q_wp_q <= ~q_wp_q;
      if (pop) q_rp_q <= ~q_rp_q;
      q_cnt_q <= q_cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem_q[q_wp_q] <= c;
  end

`ifndef SYNTHESIS
  a_no_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_cnt_q <= 2'(QDepth)) else $error("queue overflow");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> q_cnt_q == $past(q_cnt_q) + 2'd1) else $error("count slip");
  a_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> c.x < ColW'(Cols) && c.y < RowW'(Rows)) else $error("clamp");
`endif

endmodule

// ===== src/tcb_back.sv =====
// tcb_back: executes commands against the cell ram, owns cursor state
// depends on tcb_pkg and tcb_ram
module tcb_back import tcb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  output logic        cmd_ready_o,
  input  cmd_t        cmd_i,
  input  logic [7:0]  attr_i,
  input  logic        cur_en_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output res_t        res_o
);

  localparam logic [2:0] StInit  = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StFill  = 3'd2;
  localparam logic [2:0] StRead  = 3'd3;
  localparam logic [2:0] StScrRd = 3'd4;
  localparam logic [2:0] StScrWr = 3'd5;
  localparam logic [2:0] StBlank = 3'd6;
  localparam logic [2:0] StRdOut = 3'd7;

  logic [2:0] st_q, st_d;
  logic [ColW-1:0] col_q, col_d, fc_q, fc_d, fx0_q, fx0_d, fex_q, fex_d;
  logic [RowW-1:0] row_q, row_d, fr_q, fr_d, fey_q, fey_d;
  logic [HwW-1:0] hw_q, hw_d;
  logic [AddrW-1:0] ptr_q, ptr_d, addr;
  logic [7:0] ch_q, ch_d;
  logic we;
  logic [CellW-1:0] wdata, rdata;
  logic rv_q, rv_d;
  res_t res_q, res_d;
  logic [AddrW-1:0] cur_idx, xy_idx, fill_idx;

  tcb_ram #(.Width(CellW), .Depth(Cells)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  assign cur_idx  = AddrW'(row_q * Cols) + AddrW'(col_q);
  assign xy_idx   = AddrW'(cmd_i.y * Cols) + AddrW'(cmd_i.x);
  assign fill_idx = AddrW'(fr_q * Cols) + AddrW'(fc_q);
  assign cmd_ready_o = (st_q == StIdle) && !rv_q;
  assign res_valid_o = rv_q;
  assign res_o = res_q;

  always_comb begin
    logic [ColW-1:0] nc;
    logic [RowW-1:0] nr;
    logic scroll;
    st_d = st_q; col_d = col_q; row_d = row_q; hw_d = hw_q; ptr_d = ptr_q;
    fc_d = fc_q; fr_d = fr_q; fx0_d = fx0_q; fex_d = fex_q; fey_d = fey_q;
    ch_d = ch_q; rv_d = rv_q; res_d = res_q;
    we = 1'b0; addr = ptr_q; wdata = {attr_i, Space};
    nc = '0; nr = '0; scroll = 1'b0;
    if (rv_q && res_ready_i) rv_d = 1'b0;
    unique case (st_q)
      StInit: begin
        we = 1'b1; wdata = ResetCell;
        ptr_d = ptr_q + 1'b1;
        if (ptr_q == AddrW'(Cells - 1)) st_d = StIdle;
      end
      StIdle: begin
        if (cmd_valid_i && !rv_q) begin
          nc = col_q; nr = row_q;
          res_d.data = '0;
          unique case (cmd_i.req)
            ReqPut, ReqPutXy: begin
              if (cmd_i.req == ReqPutXy) begin
                if (cur_en_i && (col_q != cmd_i.x || row_q != cmd_i.y))
                  hw_d = HwW'(cmd_i.y * Cols) + HwW'(cmd_i.x);
                nc = cmd_i.x; nr = cmd_i.y;
                addr = xy_idx;
              end else begin
                addr = cur_idx;
              end
              we = 1'b1; wdata = {attr_i, cmd_i.ch};
              if (nc == ColW'(Cols - 1)) begin
                nc = '0;
                if (nr == RowW'(Rows - 1)) scroll = 1'b1;
                else nr = nr + 1'b1;
              end else begin
                nc = nc + 1'b1;
              end
            end
            ReqGoto: begin
              if (col_q != cmd_i.x || row_q != cmd_i.y) begin
                nc = cmd_i.x; nr = cmd_i.y;
                hw_d = HwW'(cmd_i.y * Cols) + HwW'(cmd_i.x);
              end
            end
            ReqFill: begin
              if (cmd_i.x < cmd_i.ex && cmd_i.y < cmd_i.ey) begin
                fc_d = cmd_i.x; fx0_d = cmd_i.x; fr_d = cmd_i.y;
                fex_d = cmd_i.ex; fey_d = cmd_i.ey; ch_d = cmd_i.ch;
                st_d = StFill;
              end
            end
            ReqClear: begin
              fc_d = '0; fx0_d = '0; fr_d = '0; ch_d = Space;
              fex_d = ColW'(Cols); fey_d = RowW'(Rows);
              st_d = StFill;
            end
            ReqRead: begin
              addr = xy_idx;
              st_d = StRead;
            end
            default: ;
          endcase
          col_d = nc; row_d = nr;
          res_d.col = nc; res_d.row = nr; res_d.hw = hw_d;
          if (scroll) begin
            ptr_d = '0; st_d = StScrRd;
          end else if (st_d == StIdle) begin
            rv_d = 1'b1;
          end
        end
      end
      StFill: begin
        we = 1'b1; addr = fill_idx; wdata = {attr_i, ch_q};
        if (fc_q + 1'b1 == fex_q) begin
          fc_d = fx0_q; fr_d = fr_q + 1'b1;
          if (fr_q + 1'b1 == fey_q) begin
            st_d = StIdle; rv_d = 1'b1;
          end
        end else begin
          fc_d = fc_q + 1'b1;
        end
      end
      StRead: begin
        // ram output holds the addressed cell in this state
        res_d.data = rdata;
        st_d = StRdOut;
      end
      StRdOut: begin
        rv_d = 1'b1; st_d = StIdle;
      end
      StScrRd: begin
        // read source cell one row down
        addr = ptr_q + AddrW'(Cols);
        st_d = StScrWr;
      end
      StScrWr: begin
        we = 1'b1; addr = ptr_q; wdata = rdata;
        ptr_d = ptr_q + 1'b1;
        if (ptr_q == AddrW'(Cols * (Rows - 1) - 1)) st_d = StBlank;
        else st_d = StScrRd;
      end
      StBlank: begin
        we = 1'b1; wdata = {attr_i, Space};
        ptr_d = ptr_q + 1'b1;
        if (ptr_q == AddrW'(Cells - 1)) begin
          st_d = StIdle; rv_d = 1'b1;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StInit; col_q <= '0; row_q <= '0; hw_q <= '0;
      ptr_q <= '0; rv_q <= 1'b0;
    end else begin
      st_q <= st_d; col_q <= col_d; row_q <= row_d; hw_q <= hw_d;
      ptr_q <= ptr_d; rv_q <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fc_q <= fc_d; fr_q <= fr_d; fx0_q <= fx0_d; fex_q <= fex_d;
    fey_q <= fey_d; ch_q <= ch_d; res_q <= res_d;
  end

`ifndef SYNTHESIS
  a_cur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q < ColW'(Cols) && row_q < RowW'(Rows)) else $error("cursor range");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != StIdle |-> !cmd_ready_o) else $error("ready while busy");
  a_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StRead |=> st_q == StRdOut) else $error("read sequence");
`endif

endmodule

// ===== src/text_console_buffer_unit.sv =====
// text_console_buffer_unit: top level of the text console buffer
// depends on tcb_pkg, tcb_front, tcb_back, tcb_ram
//
// channel | signals                         | direction
// request | in_valid_i / in_ready_o + fields | in
// result  | out_valid_o / out_ready_i + flds| out
// config  | cfg_we_i, cfg_idx_i, cfg_data_i  | in
//
// put, goto and unused codes answer straight from idle; read passes through
// a read and an output state. fill and clear write one cell at a time (one ram port).
// a put that scrolls copies each cell up one row, read then write, then blanks the last row.
// after reset a clearing pass over every cell runs before requests proceed.
// a two-entry command queue lets requests arrive while a result waits.
module text_console_buffer_unit import tcb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        req_type_i,
  input  logic signed [7:0] pos_x_i,
  input  logic signed [7:0] pos_y_i,
  input  logic [6:0]        end_x_i,
  input  logic [6:0]        end_y_i,
  input  logic [7:0]        char_code_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [6:0]        cursor_col_o,
  output logic [4:0]        cursor_row_o,
  output logic [10:0]       hw_cursor_pos_o,
  output logic [15:0]       cell_data_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [3:0]        cfg_data_i
);

  logic [3:0] fg_q, bg_q;
  logic cen_q;
  logic cmd_valid, cmd_ready;
  cmd_t cmd;
  res_t res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q <= 4'd7; bg_q <= 4'd0; cen_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegFg:    fg_q <= cfg_data_i;
        RegBg:    bg_q <= cfg_data_i;
        RegCurEn: cen_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  tcb_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .req_type_i, .pos_x_i, .pos_y_i,
    .end_x_i, .end_y_i, .char_code_i,
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  tcb_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready),
    .cmd_i(cmd), .attr_i({bg_q, fg_q}), .cur_en_i(cen_q),
    .res_valid_o(out_valid_o), .res_ready_i(out_ready_i), .res_o(res)
  );

  assign cursor_col_o    = res.col;
  assign cursor_row_o    = res.row;
  assign hw_cursor_pos_o = res.hw;
  assign cell_data_o     = res.data;

endmodule
